/* src/ucb_pkg.sv */
package ucb_pkg;

    // opcodes of an input word
    localparam logic [2:0] OPC_ADD    = 3'd0;
    localparam logic [2:0] OPC_UPDATE = 3'd1;
    localparam logic [2:0] OPC_SELECT = 3'd2;
    localparam logic [2:0] OPC_EVAL   = 3'd3;
    localparam logic [2:0] OPC_CLEAR  = 3'd4;

    // game results
    localparam logic [1:0] RES_P0_WON = 2'd0;
    localparam logic [1:0] RES_P1_WON = 2'd1;
    localparam logic [1:0] RES_DRAW   = 2'd2;

    // register map
    localparam int          APB_AW     = 2;
    localparam logic [1:0]  ADDR_EXPL  = 2'd0;
    localparam logic [15:0] EXPL_RESET = 16'd11585;

    // fixed-point constants and iteration counts
    localparam logic [31:0] LN2_Q32    = 32'd2977044472;
    localparam int          LN_W       = 21;
    localparam int          DVD_W      = LN_W + 16;
    localparam int          SQ_W       = DVD_W + 1;
    localparam int          ROOT_W     = SQ_W / 2;
    localparam logic [5:0]  LOG_STEPS  = 6'd16;
    localparam logic [5:0]  RATE_STEPS = 6'd16;
    localparam logic [5:0]  Q_STEPS    = 6'(DVD_W);
    localparam logic [5:0]  SQRT_STEPS = 6'(ROOT_W);
    localparam logic [19:0] SCORE_MAX  = 20'hFFFFF;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_ADD,
        OP_FULL,
        OP_RD_SLOT,
        OP_UPD_WR,
        OP_CLEAR,
        OP_LOG_INIT,
        OP_NORM_STEP,
        OP_LOG_LOAD,
        OP_LOG_STEP,
        OP_LN,
        OP_RD_IDX,
        OP_TAKE,
        OP_NEXT,
        OP_RATE_SAT,
        OP_RATE_INIT,
        OP_DIV_STEP,
        OP_RATE_STORE,
        OP_Q_INIT,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_BONUS,
        OP_SCORE,
        OP_EVAL_CMP,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic       tbl_full;
        logic       slot_ok;
        logic       norm_done;
        logic       idx_end;
        logic       unvisited;
        logic       rate_sat;
    } stat_t;

endpackage

/* src/ucb_ram.sv */
module ucb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/ucb_ctrl.sv */
module ucb_ctrl
    import ucb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  stat_t  stat,
    output dp_op_t op,
    output logic   busy,
    output logic   done
);

    typedef enum logic [18:0] {
        S_IDLE   = 19'd1 << 0,
        S_DECODE = 19'd1 << 1,
        S_UPD    = 19'd1 << 2,
        S_NORM   = 19'd1 << 3,
        S_LOG    = 19'd1 << 4,
        S_LN     = 19'd1 << 5,
        S_RD     = 19'd1 << 6,
        S_CHK    = 19'd1 << 7,
        S_RDIV   = 19'd1 << 8,
        S_RATE   = 19'd1 << 9,
        S_QINIT  = 19'd1 << 10,
        S_QDIV   = 19'd1 << 11,
        S_SQINIT = 19'd1 << 12,
        S_SQ     = 19'd1 << 13,
        S_BONUS  = 19'd1 << 14,
        S_SCORE  = 19'd1 << 15,
        S_EVCMP  = 19'd1 << 16,
        S_FIN    = 19'd1 << 17,
        S_DONE   = 19'd1 << 18
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       is_select;

    assign is_select = (stat.opcode == OPC_SELECT);
    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_DONE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        op         = OP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op         = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                case (stat.opcode)
                    OPC_ADD:    op = stat.tbl_full ? OP_FULL : OP_ADD;
                    OPC_UPDATE:
                    begin
                        if (stat.slot_ok)
                        begin
                            op         = OP_RD_SLOT;
                            state_next = S_UPD;
                        end
                    end
                    OPC_SELECT:
                    begin
                        op         = OP_LOG_INIT;
                        state_next = S_NORM;
                    end
                    OPC_EVAL:   state_next = S_RD;
                    OPC_CLEAR:  op = OP_CLEAR;
                    default:    op = OP_NOP;
                endcase
            end
            S_UPD:
            begin
                op         = OP_UPD_WR;
                state_next = S_DONE;
            end
            S_NORM:
            begin
                if (stat.norm_done)
                begin
                    op         = OP_LOG_LOAD;
                    cnt_next   = LOG_STEPS;
                    state_next = S_LOG;
                end
                else
                begin
                    op = OP_NORM_STEP;
                end
            end
            S_LOG:
            begin
                op       = OP_LOG_STEP;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    state_next = S_LN;
                end
            end
            S_LN:
            begin
                op         = OP_LN;
                state_next = S_RD;
            end
            S_RD:
            begin
                if (stat.idx_end)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    op         = OP_RD_IDX;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (stat.unvisited)
                begin
                    // select takes the first unvisited child, eval skips it
                    op         = is_select ? OP_TAKE : OP_NEXT;
                    state_next = is_select ? S_FIN : S_RD;
                end
                else if (stat.rate_sat)
                begin
                    op         = OP_RATE_SAT;
                    state_next = is_select ? S_QINIT : S_EVCMP;
                end
                else
                begin
                    op         = OP_RATE_INIT;
                    cnt_next   = RATE_STEPS;
                    state_next = S_RDIV;
                end
            end
            S_RDIV:
            begin
                op       = OP_DIV_STEP;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    state_next = S_RATE;
                end
            end
            S_RATE:
            begin
                op         = OP_RATE_STORE;
                state_next = is_select ? S_QINIT : S_EVCMP;
            end
            S_QINIT:
            begin
                op         = OP_Q_INIT;
                cnt_next   = Q_STEPS;
                state_next = S_QDIV;
            end
            S_QDIV:
            begin
                op       = OP_DIV_STEP;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    state_next = S_SQINIT;
                end
            end
            S_SQINIT:
            begin
                op         = OP_SQRT_INIT;
                cnt_next   = SQRT_STEPS;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                op       = OP_SQRT_STEP;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    state_next = S_BONUS;
                end
            end
            S_BONUS:
            begin
                op         = OP_BONUS;
                state_next = S_SCORE;
            end
            S_SCORE:
            begin
                op         = OP_SCORE;
                state_next = S_RD;
            end
            S_EVCMP:
            begin
                op         = OP_EVAL_CMP;
                state_next = S_RD;
            end
            S_FIN:
            begin
                op         = OP_FINISH;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* src/ucb_dp.sv */
module ucb_dp
    import ucb_pkg::*;
#(
    parameter int MAX_CHILDREN = 16,
    parameter int COUNT_BITS   = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dp_op_t             op,
    input  logic [15:0]        expl_c,
    input  logic [2:0]         opcode,
    input  logic [3:0]         child_slot,
    input  logic [1:0]         game_result,
    input  logic               mover_parity,
    output stat_t              stat,
    output logic [3:0]         chosen_child,
    output logic               none_found,
    output logic signed [15:0] move_eval,
    output logic               table_full
);

    localparam int CB = COUNT_BITS;
    localparam int HW = CB + 1;
    localparam int EW = HW + CB;
    localparam int AW = $clog2(MAX_CHILDREN);
    localparam int CW = $clog2(MAX_CHILDREN + 1);
    localparam int PW = CB + 1;

    // latched input word
    logic [2:0]  opc_reg;
    logic [3:0]  slot_reg;
    logic [1:0]  res_reg;
    logic        par_reg;

    logic [CW-1:0] count_reg;
    logic [CB-1:0] parent_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] chosen_reg;
    logic          found_reg;
    logic [19:0]   best_reg;

    logic [3:0]         res_chosen_reg;
    logic               res_none_reg;
    logic signed [15:0] res_eval_reg;
    logic               res_full_reg;

    // log unit
    logic [PW-1:0] nz_reg;
    logic [5:0]    n_reg;
    logic [30:0]   y_reg;
    logic [15:0]   frac_reg;
    logic [LN_W-1:0] ln_reg;

    // shared divider
    logic [CB-1:0]    rem_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVD_W-1:0] quot_reg;
    logic [15:0]      rate_reg;

    // square root
    logic [SQ_W-1:0]   sq_src_reg;
    logic [ROOT_W+1:0] sq_rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [21:0]       bonus_reg;

    // memory
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata, mem_rdata;
    logic [HW-1:0] hp;
    logic [CB-1:0] vis;

    logic [1:0]    pts_add;
    logic [HW:0]   hp_sum;
    logic [HW-1:0] hp_new;
    logic [CB-1:0] vis_new;

    logic [63:0]   norm_wide;
    logic [61:0]   sq_prod;
    logic [31:0]   sq_t;
    logic [53:0]   ln_sum;
    logic [CB:0]   div_r2, div_diff;
    logic          div_ge;
    logic [ROOT_W+3:0] rt_rem4, rt_trial;
    logic          rt_ge;
    logic [34:0]   bonus_prod;
    logic [22:0]   score_sum;
    logic [19:0]   score;
    logic signed [17:0] ev_w;

    ucb_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_CHILDREN)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign hp  = mem_rdata[EW-1:CB];
    assign vis = mem_rdata[CB-1:0];

    always_comb
    begin
        pts_add = 2'd0;
        if (res_reg == RES_DRAW)
        begin
            pts_add = 2'd1;
        end
        else if ((!par_reg && res_reg == RES_P1_WON) || (par_reg && res_reg == RES_P0_WON))
        begin
            pts_add = 2'd2;
        end
    end

    assign hp_sum  = (HW + 1)'(hp) + (HW + 1)'(pts_add);
    assign hp_new  = hp_sum[HW] ? {HW{1'b1}} : hp_sum[HW-1:0];
    assign vis_new = (&vis) ? vis : vis + CB'(1);

    assign mem_we    = (op == OP_ADD) || (op == OP_UPD_WR);
    assign mem_waddr = (op == OP_ADD) ? AW'(count_reg) : AW'(slot_reg);
    assign mem_wdata = (op == OP_ADD) ? '0 : {hp_new, vis_new};
    assign mem_re    = (op == OP_RD_SLOT) || (op == OP_RD_IDX);
    assign mem_raddr = (op == OP_RD_SLOT) ? AW'(slot_reg) : idx_reg[AW-1:0];

    // log2 datapath: y is Q1.30, each step squares it
    assign norm_wide = {nz_reg, {(64 - PW){1'b0}}};
    assign sq_prod   = 62'(y_reg) * 62'(y_reg);
    assign sq_t      = sq_prod[61:30];
    assign ln_sum    = 54'({n_reg, frac_reg}) * 54'(LN2_Q32) + 54'(64'd1 << 31);

    // restoring divider, one quotient bit per step
    assign div_r2   = {rem_reg, dvd_reg[DVD_W-1]};
    assign div_ge   = div_r2 >= {1'b0, vis};
    assign div_diff = div_r2 - {1'b0, vis};

    assign rt_rem4  = {sq_rem_reg, sq_src_reg[SQ_W-1:SQ_W-2]};
    assign rt_trial = (ROOT_W + 4)'({root_reg, 2'b01});
    assign rt_ge    = rt_rem4 >= rt_trial;

    assign bonus_prod = 35'(expl_c) * 35'(root_reg);
    assign score_sum  = 23'(rate_reg) + 23'(bonus_reg);
    assign score      = (score_sum > 23'(SCORE_MAX)) ? SCORE_MAX : score_sum[19:0];

    assign ev_w = par_reg ? ($signed({2'b00, best_reg[15:0]}) - 18'sd32768)
                          : (18'sd32768 - $signed({2'b00, best_reg[15:0]}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            parent_reg     <= '0;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            res_chosen_reg <= '0;
            res_none_reg   <= 1'b0;
            res_eval_reg   <= '0;
            res_full_reg   <= 1'b0;
        end
        else
        begin
            case (op)
                OP_LOAD:
                begin
                    idx_reg        <= '0;
                    found_reg      <= 1'b0;
                    res_chosen_reg <= '0;
                    res_none_reg   <= 1'b0;
                    res_eval_reg   <= '0;
                    res_full_reg   <= 1'b0;
                end
                OP_ADD:    count_reg <= count_reg + CW'(1);
                OP_FULL:   res_full_reg <= 1'b1;
                OP_UPD_WR: parent_reg <= (&parent_reg) ? parent_reg : parent_reg + CB'(1);
                OP_CLEAR:
                begin
                    count_reg  <= '0;
                    parent_reg <= '0;
                end
                OP_TAKE:   found_reg <= 1'b1;
                OP_NEXT:   idx_reg <= idx_reg + CW'(1);
                OP_SCORE:
                begin
                    if (!found_reg || score > best_reg)
                    begin
                        found_reg <= 1'b1;
                    end
                    idx_reg <= idx_reg + CW'(1);
                end
                OP_EVAL_CMP:
                begin
                    if (!found_reg || {4'b0, rate_reg} < best_reg)
                    begin
                        found_reg <= 1'b1;
                    end
                    idx_reg <= idx_reg + CW'(1);
                end
                OP_FINISH:
                begin
                    res_none_reg   <= !found_reg;
                    res_chosen_reg <= 4'(chosen_reg);
                    if (found_reg && opc_reg == OPC_EVAL)
                    begin
                        res_eval_reg <= (ev_w > 18'sd32767) ? 16'sh7FFF : ev_w[15:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                opc_reg    <= opcode;
                slot_reg   <= child_slot;
                res_reg    <= game_result;
                par_reg    <= mover_parity;
                chosen_reg <= '0;
                best_reg   <= '0;
            end
            OP_LOG_INIT:
            begin
                nz_reg <= PW'(parent_reg) + PW'(1);
                n_reg  <= 6'(PW - 1);
            end
            OP_NORM_STEP:
            begin
                nz_reg <= nz_reg << 1;
                n_reg  <= n_reg - 6'd1;
            end
            OP_LOG_LOAD:
            begin
                y_reg    <= norm_wide[63:33];
                frac_reg <= '0;
            end
            OP_LOG_STEP:
            begin
                if (sq_t[31])
                begin
                    y_reg    <= sq_t[31:1];
                    frac_reg <= {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    y_reg    <= sq_t[30:0];
                    frac_reg <= {frac_reg[14:0], 1'b0};
                end
            end
            OP_LN:     ln_reg <= ln_sum[32 +: LN_W];
            OP_TAKE:   chosen_reg <= idx_reg;
            OP_RATE_SAT: rate_reg <= 16'hFFFF;
            OP_RATE_INIT:
            begin
                // hp < 2*visits here, so the quotient fits 16 bits
                rem_reg  <= hp[HW-1:1];
                dvd_reg  <= {hp[0], {(DVD_W - 1){1'b0}}};
                quot_reg <= '0;
            end
            OP_Q_INIT:
            begin
                rem_reg  <= '0;
                dvd_reg  <= {ln_reg, 16'b0};
                quot_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                rem_reg  <= div_ge ? div_diff[CB-1:0] : div_r2[CB-1:0];
                dvd_reg  <= dvd_reg << 1;
                quot_reg <= {quot_reg[DVD_W-2:0], div_ge};
            end
            OP_RATE_STORE: rate_reg <= quot_reg[15:0];
            OP_SQRT_INIT:
            begin
                sq_src_reg <= {1'b0, quot_reg};
                sq_rem_reg <= '0;
                root_reg   <= '0;
            end
            OP_SQRT_STEP:
            begin
                if (rt_ge)
                begin
                    sq_rem_reg <= (ROOT_W + 2)'(rt_rem4 - rt_trial);
                    root_reg   <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg <= (ROOT_W + 2)'(rt_rem4);
                    root_reg   <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                sq_src_reg <= sq_src_reg << 2;
            end
            OP_BONUS:  bonus_reg <= 22'((bonus_prod + 35'd4096) >> 13);
            OP_SCORE:
            begin
                if (!found_reg || score > best_reg)
                begin
                    best_reg   <= score;
                    chosen_reg <= idx_reg;
                end
            end
            OP_EVAL_CMP:
            begin
                if (!found_reg || {4'b0, rate_reg} < best_reg)
                begin
                    best_reg   <= {4'b0, rate_reg};
                    chosen_reg <= idx_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign stat.opcode    = opc_reg;
    assign stat.tbl_full  = (count_reg == CW'(MAX_CHILDREN));
    assign stat.slot_ok   = (7'(slot_reg) < 7'(count_reg));
    assign stat.norm_done = nz_reg[PW-1];
    assign stat.idx_end   = (idx_reg == count_reg);
    assign stat.unvisited = (vis == '0);
    assign stat.rate_sat  = (hp >= {vis, 1'b0});

    assign chosen_child = res_chosen_reg;
    assign none_found   = res_none_reg;
    assign move_eval    = res_eval_reg;
    assign table_full   = res_full_reg;

endmodule

/* src/ucb1_child_select_unit.sv */
// UCB1 child selection for one search-tree node.
// Command channel: a word (opcode, child_slot, game_result, mover_parity) is taken at
// a rising edge with start high and busy low. busy stays high until the result has
// been shown; one word is in work at a time.
// Result channel: chosen_child, none_found, move_eval and table_full hold until the
// next word is taken; done marks them for one cycle. The receiver cannot stall.
// Add, clear and ignored opcodes go from decode to done; update reads its slot first.
// Eval walks the children, with a 16-step rate divide per visited child.
// Select first takes log2(parent+1) in up to COUNT_BITS normalize steps and 16
// squaring steps; then each visited child goes through the shared
// one-bit-per-cycle divider (16 steps for the rate, 37 for ln/visits) and the
// 19-step square root.
// Child statistics sit in one RAM with a registered read port.
// Reset empties the table, clears the parent count and loads the exploration
// constant with 11585 (Q3.13). The APB port holds that constant at address 0.
module ucb1_child_select_unit
    import ucb_pkg::*;
#(
    parameter int MAX_CHILDREN = 16,
    parameter int COUNT_BITS   = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         opcode,
    input  logic [3:0]         child_slot,
    input  logic [1:0]         game_result,
    input  logic               mover_parity,
    output logic               done,
    output logic [3:0]         chosen_child,
    output logic               none_found,
    output logic signed [15:0] move_eval,
    output logic               table_full,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [15:0] expl_reg;
    dp_op_t      op;
    stat_t       stat;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_EXPL) ? {16'b0, expl_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expl_reg <= EXPL_RESET;
        end
        else if (psel && penable && pwrite && paddr == ADDR_EXPL)
        begin
            expl_reg <= pwdata[15:0];
        end
    end

    ucb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .op    (op),
        .busy  (busy),
        .done  (done)
    );

    ucb_dp #(
        .MAX_CHILDREN (MAX_CHILDREN),
        .COUNT_BITS   (COUNT_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .expl_c       (expl_reg),
        .opcode       (opcode),
        .child_slot   (child_slot),
        .game_result  (game_result),
        .mover_parity (mover_parity),
        .stat         (stat),
        .chosen_child (chosen_child),
        .none_found   (none_found),
        .move_eval    (move_eval),
        .table_full   (table_full)
    );

endmodule
